// ===== hw/rtl/cpg_pkg.sv =====
// shared types and constants for the circle point generator
package cpg_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int IN_W           = 11;
    localparam int RAD_W          = 10;
    localparam int OFF_W          = 11;
    localparam int DEC_W          = 15;
    localparam int PIX_W          = 13;
    localparam int POINTS         = 8;
    localparam int IDX_W          = $clog2(POINTS);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [DEC_W-1:0] DEC_INIT   = DEC_W'(3);
    localparam logic [DEC_W-1:0] DEC_INC_X  = DEC_W'(6);
    localparam logic [DEC_W-1:0] DEC_INC_XY = DEC_W'(10);

    // one queued job: a start pixel or a full set of eight octant points
    typedef struct packed {
        logic [OFF_W-1:0] cx;
        logic [OFF_W-1:0] cy;
        logic [OFF_W-1:0] ux;
        logic [OFF_W-1:0] uy;
        logic             fin;
        logic             single;
    } job_t;

endpackage

// ===== hw/rtl/cpg_if.sv =====
// valid/ready channel interfaces for commands and pixels
interface cpg_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [cpg_pkg::IN_W-1:0]  center_x;
    logic [cpg_pkg::IN_W-1:0]  center_y;
    logic [cpg_pkg::RAD_W-1:0] radius;

    modport source (output valid, output op, output center_x, output center_y,
                    output radius, input ready);
    modport sink (input valid, input op, input center_x, input center_y,
                  input radius, output ready);
endinterface

interface cpg_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cpg_pkg::PIX_W-1:0] pixel_x;
    logic signed [cpg_pkg::PIX_W-1:0] pixel_y;
    logic                             last;
    logic                             finished;

    modport source (output valid, output pixel_x, output pixel_y, output last,
                    output finished, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input last,
                  input finished, output ready);
endinterface

// ===== hw/rtl/cpg_front.sv =====
// front end: takes commands, runs the decision update, queues pixel jobs
module cpg_front #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    cpg_in_if.sink         cmd,
    input  logic           q_full,
    output logic           q_push,
    output cpg_pkg::job_t  q_job
);
    localparam int CW = (COORD_BITS < cpg_pkg::OFF_W) ? COORD_BITS : cpg_pkg::OFF_W;

    logic [CW-1:0]                cx_reg, cx_next;
    logic [CW-1:0]                cy_reg, cy_next;
    logic [cpg_pkg::OFF_W-1:0]    ox_reg, ox_next;
    logic [cpg_pkg::OFF_W-1:0]    oy_reg, oy_next;
    logic [cpg_pkg::DEC_W-1:0]    dec_reg, dec_next;
    logic                         active_reg, active_next;
    logic                         take;
    logic [cpg_pkg::DEC_W-1:0]    x_ext, y_ext;

    assign cmd.ready = !q_full;
    assign take      = cmd.valid && cmd.ready;
    assign x_ext     = cpg_pkg::DEC_W'(ox_reg);
    assign y_ext     = cpg_pkg::DEC_W'(oy_reg);

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        dec_next    = dec_reg;
        active_next = active_reg;
        q_push      = 1'b0;
        q_job       = '0;
        if (take)
        begin
            case (cmd.op)
                cpg_pkg::OP_START:
                begin
                    cx_next     = cmd.center_x[CW-1:0];
                    cy_next     = cmd.center_y[CW-1:0];
                    ox_next     = '0;
                    oy_next     = cpg_pkg::OFF_W'(cmd.radius);
                    dec_next    = cpg_pkg::DEC_INIT - (cpg_pkg::DEC_W'(cmd.radius) << 1);
                    active_next = (cmd.radius != '0);
                    q_push      = 1'b1;
                    q_job.single = 1'b1;
                end
                cpg_pkg::OP_STEP:
                begin
                    if (active_reg)
                    begin
                        // sign bit of the decision picks the move
                        if (dec_reg[cpg_pkg::DEC_W-1])
                        begin
                            dec_next = dec_reg + (x_ext << 2) + cpg_pkg::DEC_INC_X;
                            oy_next  = oy_reg;
                        end
                        else
                        begin
                            dec_next = dec_reg + ((x_ext - y_ext) << 2) + cpg_pkg::DEC_INC_XY;
                            oy_next  = oy_reg - 1'b1;
                        end
                        ox_next      = ox_reg + 1'b1;
                        active_next  = ox_next < oy_next;
                        q_push       = 1'b1;
                        q_job.single = 1'b0;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
            q_job.cx  = cpg_pkg::OFF_W'(cx_next);
            q_job.cy  = cpg_pkg::OFF_W'(cy_next);
            q_job.ux  = ox_next;
            q_job.uy  = oy_next;
            q_job.fin = ox_next >= oy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            dec_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            dec_reg    <= dec_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== hw/rtl/cpg_queue.sv =====
// short job queue between front and back end
module cpg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpg_pkg::job_t  push_job,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output cpg_pkg::job_t  head
);
    localparam int DEPTH = cpg_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpg_pkg::job_t  mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/cpg_back.sv =====
// back end: walks one job's octant points, one pixel word per cycle while pix.ready is high
module cpg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  cpg_pkg::job_t  q_head,
    output logic           q_pop,
    cpg_out_if.source      pix
);
    cpg_pkg::job_t              job_reg;
    logic                       busy_reg;
    logic [cpg_pkg::IDX_W-1:0]  idx_reg;
    logic                       fire, at_end, load;
    logic [cpg_pkg::PIX_W-1:0]  cx_w, cy_w, a_w, b_w, dx, dy;

    assign fire   = pix.valid && pix.ready;
    assign at_end = job_reg.single || (idx_reg == cpg_pkg::IDX_W'(cpg_pkg::POINTS - 1));
    assign load   = q_not_empty && (!busy_reg || (fire && at_end));
    assign q_pop  = load;

    assign cx_w = cpg_pkg::PIX_W'(job_reg.cx);
    assign cy_w = cpg_pkg::PIX_W'(job_reg.cy);

    // bit 2 swaps the offsets, bit 0 negates the x term, bit 1 the y term
    always_comb
    begin
        a_w = idx_reg[2] ? cpg_pkg::PIX_W'(job_reg.uy) : cpg_pkg::PIX_W'(job_reg.ux);
        b_w = idx_reg[2] ? cpg_pkg::PIX_W'(job_reg.ux) : cpg_pkg::PIX_W'(job_reg.uy);
        dx  = idx_reg[0] ? -a_w : a_w;
        dy  = idx_reg[1] ? -b_w : b_w;
    end

    assign pix.valid    = busy_reg;
    assign pix.pixel_x  = cx_w + dx;
    assign pix.pixel_y  = cy_w + dy;
    assign pix.last     = at_end;
    assign pix.finished = job_reg.fin;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fire)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/circle_point_generator.sv =====
// top level of the Bresenham circle rasterizer
//
//  channel | dir | word                                   | accepted when
//  cmd     | in  | op, center_x, center_y, radius         | valid && ready
//  pix     | out | pixel_x, pixel_y, last, finished       | valid && ready
//
// a step word on a circle in progress yields eight pixel words and a start word
// one, driven out by the back end at one word per cycle while pix.ready is high,
// so a stream of steps is paced by the pixel port
// a two-entry job queue lets the front take commands while pixels drain
// rst_n clears the circle state, the queue and the output stage
module circle_point_generator #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cpg_in_if.sink     cmd,
    cpg_out_if.source  pix
);
    logic           q_push, q_pop, q_full, q_not_empty;
    cpg_pkg::job_t  q_job, q_head;

    cpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_job)
    );

    cpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    cpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pix         (pix)
    );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the Bresenham circle rasterizer
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = cpg_pkg::COORD_BITS_DEF;
    localparam int RANDOM_WORK = 165;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic                      op;
        logic [cpg_pkg::IN_W-1:0]  cx;
        logic [cpg_pkg::IN_W-1:0]  cy;
        logic [cpg_pkg::RAD_W-1:0] r;
        bit                        drain;
    } cmd_word_t;

    typedef struct packed {
        logic signed [cpg_pkg::PIX_W-1:0] px;
        logic signed [cpg_pkg::PIX_W-1:0] py;
        logic                             last;
        logic                             fin;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpg_in_if  cmd_bus ();
    cpg_out_if pix_bus ();

    circle_point_generator #(.COORD_BITS(COORD_BITS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    always #1 clk = ~clk;

    cmd_word_t cmd_queue[$];
    pixel_t    expected_pixels[$];
    int        total_words = 0;
    int        sent_count = 0;
    int        taken_count = 0;
    int        pixel_count = 0;
    int        err_count = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    bit        drain_next = 1'b0;

    // rasterizer state kept by the testbench
    logic [cpg_pkg::OFF_W-1:0]        cen_x = '0;
    logic [cpg_pkg::OFF_W-1:0]        cen_y = '0;
    logic [cpg_pkg::OFF_W-1:0]        off_x = '0;
    logic [cpg_pkg::OFF_W-1:0]        off_y = '0;
    logic signed [cpg_pkg::DEC_W-1:0] dec_var = '0;
    bit                               in_progress = 1'b0;

    function automatic int phase_now();
        if (total_words == 0)
            return 0;
        return (taken_count * 3) / total_words;
    endfunction

    task automatic add_word(input logic op, input int cx, input int cy, input int r);
        cmd_word_t w;
        w.op = op;
        w.cx = cpg_pkg::IN_W'(cx);
        w.cy = cpg_pkg::IN_W'(cy);
        w.r = cpg_pkg::RAD_W'(r);
        w.drain = drain_next;
        drain_next = 1'b0;
        cmd_queue.push_back(w);
    endtask

    task automatic push_pixel(input int px, input int py, input bit last, input bit fin);
        pixel_t p;
        p.px = cpg_pkg::PIX_W'(px);
        p.py = cpg_pkg::PIX_W'(py);
        p.last = last;
        p.fin = fin;
        expected_pixels.push_back(p);
    endtask

    // advance the rasterizer by one command word and queue the pixels it plots
    task automatic advance_circle(input logic op,
                                  input logic [cpg_pkg::IN_W-1:0] cx_in,
                                  input logic [cpg_pkg::IN_W-1:0] cy_in,
                                  input logic [cpg_pkg::RAD_W-1:0] r);
        int d;
        int x;
        int y;
        int a;
        int b;
        bit fin;
        logic [cpg_pkg::OFF_W-1:0] cmask;
        cmask = cpg_pkg::OFF_W'((1 << COORD_BITS) - 1);
        if (op == cpg_pkg::OP_START)
        begin
            cen_x = cx_in & cmask;
            cen_y = cy_in & cmask;
            off_x = '0;
            off_y = cpg_pkg::OFF_W'(r);
            dec_var = cpg_pkg::DEC_W'(3 - 2 * int'(r));
            fin = (r == 0);
            in_progress = !fin;
            push_pixel(int'(cen_x), int'(cen_y) + int'(r), 1'b1, fin);
        end
        else if (in_progress && off_x < off_y)
        begin
            d = int'(dec_var);
            x = int'(off_x);
            y = int'(off_y);
            if (d < 0)
            begin
                d = d + 4 * x + 6;
                x = x + 1;
            end
            else
            begin
                d = d + 4 * (x - y) + 10;
                x = x + 1;
                y = y - 1;
            end
            dec_var = cpg_pkg::DEC_W'(d);
            off_x = cpg_pkg::OFF_W'(x);
            off_y = cpg_pkg::OFF_W'(y);
            fin = (off_x >= off_y);
            in_progress = !fin;
            // octant order: sign of x in bit 0, sign of y in bit 1, swap in bit 2
            for (int k = 0; k < cpg_pkg::POINTS; k++)
            begin
                a = (k >= 4) ? int'(off_y) : int'(off_x);
                b = (k >= 4) ? int'(off_x) : int'(off_y);
                if (k[0])
                    a = -a;
                if (k[1])
                    b = -b;
                push_pixel(int'(cen_x) + a, int'(cen_y) + b, k == cpg_pkg::POINTS - 1, fin);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
        $display({"pixel word %0d %s: expected (%0d,%0d) last=%0b fin=%0b,",
                  " got (%0d,%0d) last=%0b fin=%0b"},
                 pixel_count, what, want.px, want.py, want.last, want.fin,
                 got.px, got.py, got.last, got.fin);
        err_count++;
    endtask

    // command driver
    always @(negedge clk)
    begin
        cmd_word_t w;
        int idle_pct;
        idle_pct = (phase_now() == 0) ? 38 : (phase_now() == 1) ? 88 : 0;
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.op <= cpg_pkg::OP_START;
            cmd_bus.center_x <= '0;
            cmd_bus.center_y <= '0;
            cmd_bus.radius <= '0;
        end
        else if (cmd_bus.valid && taken_count != sent_count)
        begin
            // word still waiting for ready
        end
        else if (cmd_queue.size() > 0
                 && !(cmd_queue[0].drain && expected_pixels.size() > 0)
                 && $urandom_range(99) >= idle_pct)
        begin
            w = cmd_queue.pop_front();
            cmd_bus.valid <= 1'b1;
            cmd_bus.op <= w.op;
            cmd_bus.center_x <= w.cx;
            cmd_bus.center_y <= w.cy;
            cmd_bus.radius <= w.r;
            sent_count <= sent_count + 1;
        end
        else
            cmd_bus.valid <= 1'b0;
    end

    // long back-pressure burst once the last phase is under way
    always @(negedge clk)
    begin
        if (rst_n && !hold_done && total_words > 0 && taken_count >= (total_words * 5) / 6)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = (phase_now() == 0) ? 88 : (phase_now() == 1) ? 38 : 0;
        if (!rst_n)
            pix_bus.ready <= 1'b0;
        else
            pix_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end

    // monitor: predict on accepted commands, check accepted pixels
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            advance_circle(cmd_bus.op, cmd_bus.center_x, cmd_bus.center_y, cmd_bus.radius);
            taken_count <= taken_count + 1;
        end
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            got.px = pix_bus.pixel_x;
            got.py = pix_bus.pixel_y;
            got.last = pix_bus.last;
            got.fin = pix_bus.finished;
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected", '0, got);
            else
            begin
                want = expected_pixels.pop_front();
                if (got.px !== want.px || got.py !== want.py
                    || got.last !== want.last || got.fin !== want.fin)
                    report_mismatch("mismatch", want, got);
            end
            pixel_count++;
        end
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int work;
        int sel;
        int r;
        int nsteps;
        bit full;
        bit drain_set;
        cmd_bus.valid = 1'b0;
        cmd_bus.op = cpg_pkg::OP_START;
        cmd_bus.center_x = '0;
        cmd_bus.center_y = '0;
        cmd_bus.radius = '0;
        pix_bus.ready = 1'b0;

        // directed words
        add_word(cpg_pkg::OP_STEP, 2047, 2047, 1023);    // step with nothing in progress
        add_word(cpg_pkg::OP_START, 0, 0, 0);            // zero radius finishes at once
        add_word(cpg_pkg::OP_STEP, 0, 0, 0);
        add_word(cpg_pkg::OP_START, 2047, 2047, 1023);
        repeat (3) add_word(cpg_pkg::OP_STEP, 0, 0, 0);
        add_word(cpg_pkg::OP_START, 0, 0, 1023);         // pixels left of and below zero
        repeat (2) add_word(cpg_pkg::OP_STEP, 2047, 2047, 1023);
        add_word(cpg_pkg::OP_START, 2047, 0, 1);
        repeat (2) add_word(cpg_pkg::OP_STEP, 0, 0, 0);  // second step after finish
        add_word(cpg_pkg::OP_START, 1024, 1024, 2);      // negative then positive decision
        repeat (3) add_word(cpg_pkg::OP_STEP, 1365, 682, 341);
        add_word(cpg_pkg::OP_START, 1365, 682, 682);
        repeat (2) add_word(cpg_pkg::OP_STEP, 682, 1365, 341);

        // random circles, mostly small ones run to completion
        work = 0;
        drain_set = 1'b0;
        while (work < RANDOM_WORK)
        begin
            sel = $urandom_range(99);
            if (!drain_set && work >= RANDOM_WORK / 2)
            begin
                drain_next = 1'b1;
                drain_set = 1'b1;
            end
            if (sel < 8)
            begin
                add_word(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(2047),
                         $urandom_range(1023));
                work++;
            end
            else
            begin
                r = (sel < 16) ? $urandom_range(1023) : $urandom_range(30);
                full = (r <= 30) && ($urandom_range(4) != 0);
                nsteps = full ? (r * 3) / 4 + 2 : $urandom_range(12);
                add_word(cpg_pkg::OP_START, $urandom_range(2047), $urandom_range(2047), r);
                repeat (nsteps)
                    add_word(cpg_pkg::OP_STEP, $urandom_range(2047), $urandom_range(2047),
                             $urandom_range(1023));
                work += 1 + (full ? (r * 7) / 10 : nsteps);
            end
        end
        total_words = cmd_queue.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (taken_count != total_words || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0 && expected_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
